// File: rtl/ruf_pkg.sv
// Shared definitions for the RS485 UART ring-buffer controller.
// Holds event codes, status codes and the controller-to-datapath command struct.
// No dependencies.
package ruf_pkg;

    // event codes carried on the input tuser
    localparam logic [2:0] OP_PUT      = 3'd0;
    localparam logic [2:0] OP_GET      = 3'd1;
    localparam logic [2:0] OP_RX_BYTE  = 3'd2;
    localparam logic [2:0] OP_HOLD_EMP = 3'd3;
    localparam logic [2:0] OP_TX_DONE  = 3'd4;

    // status codes carried on the output tuser
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TX_FULL  = 2'd1;
    localparam logic [1:0] ST_RX_EMPTY = 2'd2;

    // field widths
    localparam int OP_W    = 3;
    localparam int BYTE_W  = 8;
    localparam int TICK_W  = 32;
    localparam int STAT_W  = 2;
    localparam int IN_DW   = 40;
    localparam int OUT_DW  = 88;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;   // latch the incoming word
        logic mem_read;  // read both rings at their tail pointers
        logic execute;   // apply the event and load the result register
    } ruf_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic out_free;  // result register can take a new word
    } ruf_stat_t;

endpackage

// File: rtl/ruf_ctrl.sv
// Controller state machine for the RS485 UART ring-buffer controller.
// Sequences capture, ring read and execute; uses ruf_pkg command/status types.
module ruf_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  ruf_pkg::ruf_stat_t  dp_stat,
    output ruf_pkg::ruf_cmd_t   dp_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_EXEC = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next     = state_reg;
        dp_cmd.capture  = 1'b0;
        dp_cmd.mem_read = 1'b0;
        dp_cmd.execute  = 1'b0;
        s_tready        = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    dp_cmd.capture = 1'b1;
                    state_next     = S_READ;
                end
            end
            S_READ: begin
                dp_cmd.mem_read = 1'b1;
                state_next      = S_EXEC;
            end
            S_EXEC: begin
                if (dp_stat.out_free) begin
                    dp_cmd.execute = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/ruf_datapath.sv
// Datapath for the RS485 UART ring-buffer controller: rings, pointers, flags,
// stamps and the result register. Driven by ruf_ctrl through ruf_pkg types.
module ruf_datapath #(
    parameter int RING_DEPTH = 64
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  ruf_pkg::ruf_cmd_t           dp_cmd,
    output ruf_pkg::ruf_stat_t          dp_stat,
    input  logic [ruf_pkg::OP_W-1:0]    in_op,
    input  logic [ruf_pkg::BYTE_W-1:0]  in_byte,
    input  logic [ruf_pkg::TICK_W-1:0]  in_tick,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [ruf_pkg::OUT_DW-1:0]  m_tdata,
    output logic [ruf_pkg::STAT_W-1:0]  m_tuser
);

    localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(RING_DEPTH - 1);

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        ring_next = (p == LAST_IDX) ? '0 : p + PTR_W'(1);
    endfunction

    // ring memories
    logic [ruf_pkg::BYTE_W-1:0] send_ring [RING_DEPTH];
    logic [ruf_pkg::BYTE_W-1:0] recv_ring [RING_DEPTH];

    // captured event word
    logic [ruf_pkg::OP_W-1:0]   op_reg;
    logic [ruf_pkg::BYTE_W-1:0] byte_reg;
    logic [ruf_pkg::TICK_W-1:0] tick_reg;

    // registered ring reads
    logic [ruf_pkg::BYTE_W-1:0] send_rd_reg, recv_rd_reg;

    // control state
    logic [PTR_W-1:0] send_head_reg, send_head_next;
    logic [PTR_W-1:0] send_tail_reg, send_tail_next;
    logic [PTR_W-1:0] recv_head_reg, recv_head_next;
    logic [PTR_W-1:0] recv_tail_reg, recv_tail_next;
    logic holding_free_reg, holding_free_next;
    logic watch_empty_reg, watch_empty_next;
    logic watch_complete_reg, watch_complete_next;
    logic drive_on_reg, drive_on_next;
    logic [ruf_pkg::TICK_W-1:0] tx_stamp_reg, tx_stamp_next;
    logic [ruf_pkg::TICK_W-1:0] rx_stamp_reg, rx_stamp_next;

    // per-event results
    logic [ruf_pkg::STAT_W-1:0] status_c;
    logic [ruf_pkg::BYTE_W-1:0] read_byte_c, line_byte_c;
    logic                       line_send_c;
    logic                       send_we, recv_we;
    logic [PTR_W-1:0]           send_nx, recv_nx;

    // result register
    logic                        out_valid_reg;
    logic [ruf_pkg::OUT_DW-1:0]  out_data_reg;
    logic [ruf_pkg::STAT_W-1:0]  out_user_reg;

    assign dp_stat.out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    assign send_nx = ring_next(send_head_reg);
    assign recv_nx = ring_next(recv_head_reg);

    // event capture
    always_ff @(posedge aclk) begin
        if (dp_cmd.capture) begin
            op_reg   <= in_op;
            byte_reg <= in_byte;
            tick_reg <= in_tick;
        end
    end

    // ring memories: read at tail pointers, write on execute
    always_ff @(posedge aclk) begin
        if (dp_cmd.mem_read) begin
            send_rd_reg <= send_ring[send_tail_reg];
            recv_rd_reg <= recv_ring[recv_tail_reg];
        end
        if (send_we) begin
            send_ring[send_head_reg] <= byte_reg;
        end
        if (recv_we) begin
            recv_ring[recv_head_reg] <= byte_reg;
        end
    end

    // event decode and next state
    always_comb begin
        status_c            = ruf_pkg::ST_OK;
        read_byte_c         = '0;
        line_send_c         = 1'b0;
        line_byte_c         = '0;
        send_we             = 1'b0;
        recv_we             = 1'b0;
        send_head_next      = send_head_reg;
        send_tail_next      = send_tail_reg;
        recv_head_next      = recv_head_reg;
        recv_tail_next      = recv_tail_reg;
        holding_free_next   = holding_free_reg;
        watch_empty_next    = watch_empty_reg;
        watch_complete_next = watch_complete_reg;
        drive_on_next       = drive_on_reg;
        tx_stamp_next       = tx_stamp_reg;
        rx_stamp_next       = rx_stamp_reg;
        if (dp_cmd.execute) begin
            unique case (op_reg)
                ruf_pkg::OP_PUT: begin
                    if (send_head_reg == send_tail_reg && holding_free_reg) begin
                        // direct hand-off to the shifter
                        line_send_c         = 1'b1;
                        line_byte_c         = byte_reg;
                        holding_free_next   = 1'b0;
                        watch_complete_next = 1'b1;
                        drive_on_next       = 1'b1;
                    end else if (send_nx == send_tail_reg) begin
                        status_c = ruf_pkg::ST_TX_FULL;
                    end else begin
                        send_we             = 1'b1;
                        send_head_next      = send_nx;
                        watch_empty_next    = 1'b1;
                        watch_complete_next = 1'b0;
                    end
                end
                ruf_pkg::OP_GET: begin
                    if (recv_head_reg == recv_tail_reg) begin
                        status_c = ruf_pkg::ST_RX_EMPTY;
                    end else begin
                        read_byte_c    = recv_rd_reg;
                        recv_tail_next = ring_next(recv_tail_reg);
                    end
                end
                ruf_pkg::OP_RX_BYTE: begin
                    // overwrite oldest byte when full
                    rx_stamp_next  = tick_reg;
                    recv_we        = 1'b1;
                    recv_head_next = recv_nx;
                    if (recv_nx == recv_tail_reg) begin
                        recv_tail_next = ring_next(recv_tail_reg);
                    end
                end
                ruf_pkg::OP_HOLD_EMP: begin
                    holding_free_next = 1'b1;
                    if (watch_empty_reg) begin
                        if (send_head_reg == send_tail_reg) begin
                            watch_empty_next = 1'b0;
                        end else begin
                            line_send_c       = 1'b1;
                            line_byte_c       = send_rd_reg;
                            send_tail_next    = ring_next(send_tail_reg);
                            holding_free_next = 1'b0;
                            tx_stamp_next     = tick_reg;
                            if (send_head_reg == ring_next(send_tail_reg)) begin
                                watch_empty_next    = 1'b0;
                                watch_complete_next = 1'b1;
                            end
                        end
                    end
                end
                ruf_pkg::OP_TX_DONE: begin
                    if (watch_complete_reg) begin
                        tx_stamp_next       = tick_reg;
                        watch_complete_next = 1'b0;
                        drive_on_next       = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // control state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            send_head_reg      <= '0;
            send_tail_reg      <= '0;
            recv_head_reg      <= '0;
            recv_tail_reg      <= '0;
            holding_free_reg   <= 1'b1;
            watch_empty_reg    <= 1'b0;
            watch_complete_reg <= 1'b0;
            drive_on_reg       <= 1'b0;
            tx_stamp_reg       <= '0;
            rx_stamp_reg       <= '0;
        end else begin
            send_head_reg      <= send_head_next;
            send_tail_reg      <= send_tail_next;
            recv_head_reg      <= recv_head_next;
            recv_tail_reg      <= recv_tail_next;
            holding_free_reg   <= holding_free_next;
            watch_empty_reg    <= watch_empty_next;
            watch_complete_reg <= watch_complete_next;
            drive_on_reg       <= drive_on_next;
            tx_stamp_reg       <= tx_stamp_next;
            rx_stamp_reg       <= rx_stamp_next;
        end
    end

    // result register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (dp_cmd.execute) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge aclk) begin
        if (dp_cmd.execute) begin
            out_user_reg <= status_c;
            out_data_reg <= {6'd0, rx_stamp_next, tx_stamp_next, drive_on_next,
                             line_byte_c, line_send_c, read_byte_c};
        end
    end

endmodule

// File: rtl/rs485_uart_fifo_controller.sv
// Top level of the RS485 UART ring-buffer controller.
// Event words enter on the s_ stream, one result word per event leaves on m_.
// Each event passes through capture, a registered ring read and execute, and
// the next event is accepted only once the last one has executed.
// The ring read is a step of its own: both rings are read at their tail
// pointers before the event is applied.
// s_tready is high only while the controller waits for a new event.
// The result is held in an output register; while m_tready is low the next
// event is still accepted and read, and it waits in its execute step until
// the held result is taken. m_tvalid is set by the execute step.
// After reset both rings are empty, the holding register is free, the driver
// is disabled, both stamps are zero and no result is pending. Ring contents
// need no clearing: a value read is used only from written entries.
// Put, get, line-receive, holding-empty and transmit-complete events are
// coded on s_tuser; unused codes produce an ok result with no change.
// Depends on ruf_pkg, ruf_ctrl and ruf_datapath.
module rs485_uart_fifo_controller #(
    parameter int RING_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // data_byte[7:0], tick_now[39:8]
    input  logic [2:0]  s_tuser,   // opcode[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // read_byte[7:0], line_send[8], line_byte[16:9],
                                   // driver_enable[17], last_tx_time[49:18],
                                   // last_rx_time[81:50], zeros[87:82]
    output logic [1:0]  m_tuser    // status[1:0]
);

    ruf_pkg::ruf_cmd_t  dp_cmd;
    ruf_pkg::ruf_stat_t dp_stat;

    // event sequencer
    ruf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .dp_stat  (dp_stat),
        .dp_cmd   (dp_cmd)
    );

    // rings, flags and result register
    ruf_datapath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .dp_cmd   (dp_cmd),
        .dp_stat  (dp_stat),
        .in_op    (s_tuser),
        .in_byte  (s_tdata[7:0]),
        .in_tick  (s_tdata[39:8]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
